// File: rtl/bvtm_pkg.sv
// bvtm_pkg: constants, register map and fixed-point helpers for the
// battery voltage / temperature monitor
// no dependencies
package bvtm_pkg;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_VOLT_LOW    = 3'd0,
    REG_VOLT_HIGH   = 3'd1,
    REG_TEMP_LIMIT  = 3'd2,
    REG_VOLT_ALARM  = 3'd3,
    REG_LIST_PERIOD = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [7:0] VOLT_LOW_RST    = 8'd40;
  localparam logic [7:0] VOLT_HIGH_RST   = 8'd60;
  localparam logic [7:0] TEMP_LIMIT_RST  = 8'd50;
  localparam logic       VOLT_ALARM_RST  = 1'b0;
  localparam logic [7:0] LIST_PERIOD_RST = 8'd90;

  // alarm repeat periods
  localparam logic [3:0] TEMP_PUSH_PERIOD = 4'd15;
  localparam logic [1:0] TAKEOVER_PERIOD  = 2'd2;

  // mv * 69 * 256 / 1000 == mv * 2208 / 125
  localparam logic [23:0] SCALE_NUM   = 24'd2208;
  localparam logic [23:0] SCALE_DEN   = 24'd125;
  // floor(2^24 / 125): quotient estimate is exact or one low
  localparam logic [40:0] SCALE_RECIP = 41'd134217;
  localparam int unsigned SCALE_SHIFT = 24;

  // filter: (f*49 + s + 25) / 50, done as ((...) >> 1) / 25
  localparam logic [21:0] FILT_KEEP   = 22'd49;
  localparam logic [21:0] FILT_ROUND  = 22'd25;
  localparam logic [20:0] FILT_DEN    = 21'd25;
  // floor(2^21 / 25): quotient estimate is exact or one low
  localparam logic [37:0] FILT_RECIP  = 38'd83886;
  localparam int unsigned FILT_SHIFT  = 21;

  // millivolts, scaled by 69, to volts in 8.8, floored and saturated
  function automatic logic [15:0] scale_sample(input logic [11:0] mv);
    logic [23:0] x;
    logic [40:0] prod;
    logic [16:0] q;
    logic [23:0] rem;
    x    = 24'(mv) * SCALE_NUM;
    prod = 41'(x) * SCALE_RECIP;
    q    = prod[SCALE_SHIFT +: 17];
    rem  = x - 24'(q) * SCALE_DEN;
    // estimate may be one short
    if (rem >= SCALE_DEN) begin
      q = q + 17'd1;
    end
    return (q > 17'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  // one step of the 1/50 filter, rounded half up; result never exceeds 16 bits
  function automatic logic [15:0] filter_step(input logic [15:0] filt,
                                              input logic [15:0] sample);
    logic [21:0] y;
    logic [20:0] z;
    logic [37:0] prod;
    logic [16:0] q;
    logic [20:0] rem;
    y    = 22'(filt) * FILT_KEEP + 22'(sample) + FILT_ROUND;
    z    = y[21:1];
    prod = 38'(z) * FILT_RECIP;
    q    = prod[FILT_SHIFT +: 17];
    rem  = z - 21'(q) * FILT_DEN;
    if (rem >= FILT_DEN) begin
      q = q + 17'd1;
    end
    return q[15:0];
  endfunction

endpackage

// File: rtl/battery_voltage_temp_monitor.sv
// battery_voltage_temp_monitor: supply hysteresis, temperature alarm,
// takeover and list refresh requests, low-pass voltage filter
// depends on bvtm_pkg
//
// channel  direction  handshake          payload
// in_      slave      tvalid / tready    tdata: reading_mv, temperature
// out_     master     tvalid / tready    tdata: one result per tick
// cfg_     apb        psel/penable       5 registers at byte address 4*i
//
// one tick per cycle sustained while out_tready does not stall the result
// stage one holds the tick and its scaled sample, stage two the result
// the filter and alarm state update as a tick moves from stage one to two,
// so the next tick sees it the following cycle
// reset is synchronous; a stalled result holds stage one, which fills and
// then deasserts in_tready
module battery_voltage_temp_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  // reading_mv [11:0], temperature [19:12], zero [23:20]
  input  logic [bvtm_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // warning [0], report_valid [1], report_volts [9:2], report_temp_alarm [10],
  // temp_alarm_push [11], temp_alarm_clear [12], takeover_fire [13],
  // supply_normal [14], list_request [15]
  output logic [bvtm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [bvtm_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [bvtm_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [bvtm_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import bvtm_pkg::*;

  // configuration registers
  logic [7:0] volt_low_r;
  logic [7:0] volt_high_r;
  logic [7:0] temp_limit_r;
  logic       volt_alarm_r;
  logic [7:0] list_period_r;

  // stage one
  logic        s1_valid_r;
  logic [15:0] s1_sample_r;
  logic [7:0]  s1_temp_r;

  // result stage
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // monitor state
  logic [15:0] filt_r,        filt_nxt;
  logic        seeded_r;
  logic        volt_ok_r,     volt_ok_nxt;
  logic [7:0]  last_volts_r;
  logic        volt_seen_r,   volt_seen_nxt;
  logic        temp_seen_r,   temp_seen_nxt;
  logic [3:0]  temp_cnt_r,    temp_cnt_nxt;
  logic [1:0]  take_cnt_r,    take_cnt_nxt;
  logic [7:0]  list_cnt_r,    list_cnt_nxt;

  logic                  s2_ready;
  logic                  advance;
  logic                  cfg_wr;
  logic [OUT_DATA_W-1:0] res_nxt;

  // result fields
  logic       volts_lt_low;
  logic [7:0] volts;
  logic       temp_ok;
  logic       warning;
  logic       rep_valid;
  logic [7:0] rep_volts;
  logic       rep_alarm;
  logic       push;
  logic       clr;
  logic       fire;
  logic       list_req;
  logic [1:0] take_base;

  // handshakes
  assign s2_ready   = !out_valid_r || out_tready;
  assign advance    = s1_valid_r && s2_ready;
  assign in_tready  = !s1_valid_r || s2_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register read mux
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[4:2])
      REG_VOLT_LOW:    cfg_prdata = CFG_DATA_W'(volt_low_r);
      REG_VOLT_HIGH:   cfg_prdata = CFG_DATA_W'(volt_high_r);
      REG_TEMP_LIMIT:  cfg_prdata = CFG_DATA_W'(temp_limit_r);
      REG_VOLT_ALARM:  cfg_prdata = CFG_DATA_W'(volt_alarm_r);
      REG_LIST_PERIOD: cfg_prdata = CFG_DATA_W'(list_period_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_low_r    <= VOLT_LOW_RST;
      volt_high_r   <= VOLT_HIGH_RST;
      temp_limit_r  <= TEMP_LIMIT_RST;
      volt_alarm_r  <= VOLT_ALARM_RST;
      list_period_r <= LIST_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_VOLT_LOW:    volt_low_r    <= cfg_pwdata[7:0];
        REG_VOLT_HIGH:   volt_high_r   <= cfg_pwdata[7:0];
        REG_TEMP_LIMIT:  temp_limit_r  <= cfg_pwdata[7:0];
        REG_VOLT_ALARM:  volt_alarm_r  <= cfg_pwdata[0];
        REG_LIST_PERIOD: list_period_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // tick evaluation against state as it stood before this tick
  always_comb begin
    volts = filt_r[15:8];

    // list refresh divider
    if (list_cnt_r < list_period_r) begin
      list_cnt_nxt = list_cnt_r + 8'd1;
      list_req     = 1'b0;
    end else begin
      list_cnt_nxt = '0;
      list_req     = 1'b1;
    end

    // voltage hysteresis; high limit wins when both apply
    volts_lt_low = volts < volt_low_r;
    volt_ok_nxt  = volt_ok_r;
    if (volts_lt_low) begin
      volt_ok_nxt = 1'b0;
    end
    if (volts >= volt_high_r) begin
      volt_ok_nxt = 1'b1;
    end
    temp_ok = s1_temp_r < temp_limit_r;

    warning = (!volt_ok_nxt && volt_alarm_r) || !temp_ok;

    // change report
    rep_valid = last_volts_r != volts;
    rep_volts = rep_valid ? volts : 8'd0;
    rep_alarm = rep_valid && !temp_ok;

    // periodic temperature alarm and clear on recovery
    temp_seen_nxt = temp_seen_r;
    temp_cnt_nxt  = temp_cnt_r;
    push          = 1'b0;
    clr           = 1'b0;
    if (!temp_ok) begin
      temp_seen_nxt = 1'b0;
      if (temp_cnt_r < TEMP_PUSH_PERIOD) begin
        temp_cnt_nxt = temp_cnt_r + 4'd1;
      end else begin
        temp_cnt_nxt = '0;
        push         = 1'b1;
      end
    end else if (!temp_seen_r) begin
      temp_seen_nxt = 1'b1;
      clr           = 1'b1;
    end

    // takeover: on entry, every third tick, once on recovery
    volt_seen_nxt = volt_seen_r;
    take_cnt_nxt  = take_cnt_r;
    take_base     = volt_seen_r ? TAKEOVER_PERIOD : take_cnt_r;
    fire          = 1'b0;
    if (!volt_ok_nxt) begin
      volt_seen_nxt = 1'b0;
      if (take_base < TAKEOVER_PERIOD) begin
        take_cnt_nxt = take_base + 2'd1;
      end else begin
        take_cnt_nxt = '0;
        fire         = 1'b1;
      end
    end else if (!volt_seen_r) begin
      volt_seen_nxt = 1'b1;
      fire          = 1'b1;
    end

    // filter update; first sample seeds it
    filt_nxt = seeded_r ? filter_step(filt_r, s1_sample_r) : s1_sample_r;

    res_nxt = {list_req, volt_ok_nxt, fire, clr, push, rep_alarm, rep_volts,
               rep_valid, warning};
  end

  // control and monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      filt_r       <= '0;
      seeded_r     <= 1'b0;
      volt_ok_r    <= 1'b1;
      last_volts_r <= '0;
      volt_seen_r  <= 1'b1;
      temp_seen_r  <= 1'b1;
      temp_cnt_r   <= '0;
      take_cnt_r   <= '0;
      list_cnt_r   <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        filt_r       <= filt_nxt;
        seeded_r     <= 1'b1;
        volt_ok_r    <= volt_ok_nxt;
        last_volts_r <= volts;
        volt_seen_r  <= volt_seen_nxt;
        temp_seen_r  <= temp_seen_nxt;
        temp_cnt_r   <= temp_cnt_nxt;
        take_cnt_r   <= take_cnt_nxt;
        list_cnt_r   <= list_cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= scale_sample(in_tdata[11:0]);
      s1_temp_r   <= in_tdata[19:12];
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  // checks
  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[9:2] == 8'd0 && !out_tdata[10])
    else $error("report fields set without report_valid");

  a_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[11] && out_tdata[12]))
    else $error("temperature push and clear in the same result");

  a_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> seeded_r && out_valid_r)
    else $error("tick moved on without seeding filter or producing a result");

  a_take_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    take_cnt_r <= TAKEOVER_PERIOD)
    else $error("takeover counter out of range");

endmodule
